// ===== src/hcd_pkg.sv =====
// Shared types, constants and register codes of the HSV color and depth point filter.
package hcd_pkg;

    localparam int COORD_W  = 32;
    localparam int COLOR_W  = 8;
    localparam int HUE_W    = 15;
    localparam int Q12_W    = 13;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 32;

    // Hue sector arithmetic: hue = (7680 * x + diff) / (2 * diff), x at most 6 * 255.
    localparam int SECT_W = 11;
    localparam logic [HUE_W-1:0] HUE_FULL = 15'd23040;

    // Divider geometry shared by the saturation and hue lanes.
    localparam int DIV_NUM_W = 24;
    localparam int DIV_DEN_W = 9;
    localparam int DIV_QUO_W = 15;

    localparam logic [DIV_NUM_W-1:0] HUE_NUM_SCALE = 24'd7680;

    // Value is round(max * 4096 / 255) = floor((4096 * max + 127) / 255). The reciprocal
    // multiply by ceil(2^28 / 255) is exact for every 8-bit max.
    localparam int VAL_NUM_W  = 20;
    localparam int VAL_PROD_W = 41;
    localparam int VAL_SHIFT  = 28;
    localparam logic [VAL_NUM_W-1:0]  VAL_ROUND = 20'd127;
    localparam logic [VAL_PROD_W-1:0] VAL_RECIP = 41'd1052689;

    // Pipeline layout: two front stages, one stage per quotient bit, two back stages.
    localparam int FRONT_STAGES = 2;
    localparam int BACK_STAGES  = 2;
    localparam int PIPE_DEPTH   = FRONT_STAGES + DIV_QUO_W + BACK_STAGES;
    localparam int DIV_OUT_TAP  = FRONT_STAGES + DIV_QUO_W - 1;
    localparam int BACK_P1_TAP  = DIV_OUT_TAP + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEPTH_LIMIT = 3'd0,
        CFG_TARGET_HUE  = 3'd1,
        CFG_HUE_TOL     = 3'd2,
        CFG_SAT_LOW     = 3'd3,
        CFG_SAT_HIGH    = 3'd4,
        CFG_VAL_LOW     = 3'd5,
        CFG_VAL_HIGH    = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic signed [COORD_W-1:0] x_coord;
        logic signed [COORD_W-1:0] y_coord;
        logic signed [COORD_W-1:0] z_coord;
        logic [COLOR_W-1:0]        red;
        logic [COLOR_W-1:0]        green;
        logic [COLOR_W-1:0]        blue;
        logic                      last_in_cloud;
    } t_in_item;

    typedef struct packed {
        logic                      keep;
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic signed [COORD_W-1:0] out_z;
        logic [COLOR_W-1:0]        out_red;
        logic [COLOR_W-1:0]        out_green;
        logic [COLOR_W-1:0]        out_blue;
        logic                      out_last;
    } t_out_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] depth_limit;
        logic [HUE_W-1:0]          target_hue;
        logic [HUE_W-1:0]          hue_tolerance;
        logic [Q12_W-1:0]          sat_low;
        logic [Q12_W-1:0]          sat_high;
        logic [Q12_W-1:0]          val_low;
        logic [Q12_W-1:0]          val_high;
    } t_cfg;

    typedef struct packed {
        logic [DIV_NUM_W-1:0] sat_num;
        logic [DIV_DEN_W-1:0] sat_den;
        logic [DIV_NUM_W-1:0] hue_num;
        logic [DIV_DEN_W-1:0] hue_den;
        logic [Q12_W-1:0]     val;
    } t_div_ops;

    localparam t_cfg CFG_RESET = '{
        depth_limit:   32'sd5898240,
        target_hue:    15'd0,
        hue_tolerance: 15'd1280,
        sat_low:       13'd1229,
        sat_high:      13'd4096,
        val_low:       13'd1229,
        val_high:      13'd4096
    };

endpackage

// ===== src/hcd_front.sv =====
// Front stages: color max/min and sector, then the divider operands and the value.
module hcd_front (
    input  logic              i_clk,
    input  logic              i_en,
    input  hcd_pkg::t_in_item i_item,
    output hcd_pkg::t_div_ops o_ops
);
    import hcd_pkg::*;

    logic [COLOR_W-1:0] mx;
    logic [COLOR_W-1:0] mn;
    logic [COLOR_W-1:0] diff;
    logic [SECT_W-1:0]  sect;

    logic [COLOR_W-1:0]    r_mx;
    logic [COLOR_W-1:0]    r_diff;
    logic [SECT_W-1:0]     r_sect;
    logic [VAL_NUM_W-1:0]  val_num;
    logic [VAL_PROD_W-1:0] val_prod;
    t_div_ops              n_ops;
    t_div_ops              r_ops;

    // Stage one: max, min and the sector term sect, which is never negative.
    always_comb begin
        mx = i_item.red;
        mn = i_item.red;
        if (i_item.green > mx) mx = i_item.green;
        if (i_item.blue > mx) mx = i_item.blue;
        if (i_item.green < mn) mn = i_item.green;
        if (i_item.blue < mn) mn = i_item.blue;
        diff = mx - mn;
        if (mx == i_item.red) begin
            if (i_item.green >= i_item.blue) begin
                sect = SECT_W'(i_item.green) - SECT_W'(i_item.blue);
            end else begin
                sect = SECT_W'(diff) * SECT_W'(6) - SECT_W'(i_item.blue)
                       + SECT_W'(i_item.green);
            end
        end else if (mx == i_item.green) begin
            sect = (SECT_W'(diff) << 1) + SECT_W'(i_item.blue) - SECT_W'(i_item.red);
        end else begin
            sect = (SECT_W'(diff) << 2) + SECT_W'(i_item.red) - SECT_W'(i_item.green);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mx   <= mx;
            r_diff <= diff;
            r_sect <= sect;
        end
    end

    // Stage two: numerators carry the half-divisor term for round half up.
    always_comb begin
        n_ops.sat_num = (DIV_NUM_W'(r_diff) << 13) + DIV_NUM_W'(r_mx);
        n_ops.sat_den = DIV_DEN_W'(r_mx) << 1;
        n_ops.hue_num = DIV_NUM_W'(r_sect) * HUE_NUM_SCALE + DIV_NUM_W'(r_diff);
        n_ops.hue_den = DIV_DEN_W'(r_diff) << 1;
        val_num       = (VAL_NUM_W'(r_mx) << 12) + VAL_ROUND;
        val_prod      = VAL_PROD_W'(val_num) * VAL_RECIP;
        n_ops.val     = val_prod[VAL_SHIFT +: Q12_W];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ops <= n_ops;
        end
    end

    assign o_ops = r_ops;

endmodule

// ===== src/hcd_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module hcd_div (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [hcd_pkg::DIV_NUM_W-1:0] i_num,
    input  logic [hcd_pkg::DIV_DEN_W-1:0] i_den,
    output logic [hcd_pkg::DIV_QUO_W-1:0] o_quo
);
    import hcd_pkg::*;

    logic [DIV_NUM_W-1:0] r_rem [DIV_QUO_W];
    logic [DIV_DEN_W-1:0] r_den [DIV_QUO_W];
    logic [DIV_QUO_W-1:0] r_quo [DIV_QUO_W];

    logic [DIV_NUM_W-1:0] n_rem [DIV_QUO_W];
    logic [DIV_QUO_W-1:0] n_quo [DIV_QUO_W];
    logic [DIV_NUM_W-1:0] src_rem [DIV_QUO_W];
    logic [DIV_DEN_W-1:0] src_den [DIV_QUO_W];
    logic [DIV_QUO_W-1:0] src_quo [DIV_QUO_W];
    logic [DIV_NUM_W-1:0] shifted [DIV_QUO_W];

    // Stage k decides quotient bit DIV_QUO_W-1-k; the quotient is known to fit.
    always_comb begin
        for (int k = 0; k < DIV_QUO_W; k++) begin
            if (k == 0) begin
                src_rem[k] = i_num;
                src_den[k] = i_den;
                src_quo[k] = '0;
            end else begin
                src_rem[k] = r_rem[k-1];
                src_den[k] = r_den[k-1];
                src_quo[k] = r_quo[k-1];
            end
            shifted[k] = DIV_NUM_W'(src_den[k]) << (DIV_QUO_W - 1 - k);
            if (src_rem[k] >= shifted[k]) begin
                n_rem[k] = src_rem[k] - shifted[k];
                n_quo[k] = src_quo[k] | (DIV_QUO_W'(1) << (DIV_QUO_W - 1 - k));
            end else begin
                n_rem[k] = src_rem[k];
                n_quo[k] = src_quo[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < DIV_QUO_W; k++) begin
                r_rem[k] <= n_rem[k];
                r_den[k] <= src_den[k];
                r_quo[k] <= n_quo[k];
            end
        end
    end

    assign o_quo = r_quo[DIV_QUO_W-1];

endmodule

// ===== src/hcd_back.sv =====
// Back stages: hue fix-up and distance, then the threshold decision.
module hcd_back (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  hcd_pkg::t_cfg                 i_cfg,
    input  logic [hcd_pkg::DIV_QUO_W-1:0] i_sat_quo,
    input  logic [hcd_pkg::DIV_QUO_W-1:0] i_hue_quo,
    input  logic [hcd_pkg::Q12_W-1:0]     i_val,
    input  hcd_pkg::t_in_item             i_item_div,
    input  hcd_pkg::t_in_item             i_item_p1,
    output logic                          o_keep
);
    import hcd_pkg::*;

    logic             black;
    logic             gray;
    logic [HUE_W-1:0] hue;
    logic [HUE_W-1:0] n_d1;
    logic [Q12_W-1:0] n_sat;

    logic [HUE_W-1:0] r_d1;
    logic [Q12_W-1:0] r_sat;
    logic [Q12_W-1:0] r_val;

    logic [HUE_W-1:0] d2;
    logic [HUE_W-1:0] hue_gap;
    logic             n_keep;
    logic             r_keep;

    always_comb begin
        black = (i_item_div.red | i_item_div.green | i_item_div.blue) == '0;
        gray  = (i_item_div.red == i_item_div.green) && (i_item_div.green == i_item_div.blue);
        if (black || gray) begin
            hue = '0;
        end else if (i_hue_quo >= HUE_FULL) begin
            hue = i_hue_quo - HUE_FULL;
        end else begin
            hue = i_hue_quo;
        end
        n_sat = black ? '0 : i_sat_quo[Q12_W-1:0];
        if (hue >= i_cfg.target_hue) begin
            n_d1 = hue - i_cfg.target_hue;
        end else begin
            n_d1 = i_cfg.target_hue - hue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d1  <= n_d1;
            r_sat <= n_sat;
            r_val <= i_val;
        end
    end

    // The hue circle wraps, so the distance is the shorter way around.
    always_comb begin
        if (r_d1 <= HUE_FULL) begin
            d2 = HUE_FULL - r_d1;
        end else begin
            d2 = r_d1 - HUE_FULL;
        end
        hue_gap = (r_d1 < d2) ? r_d1 : d2;
        n_keep = (i_item_p1.z_coord < i_cfg.depth_limit)
                 && (hue_gap < i_cfg.hue_tolerance)
                 && (r_sat > i_cfg.sat_low) && (r_sat < i_cfg.sat_high)
                 && (r_val > i_cfg.val_low) && (r_val < i_cfg.val_high);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_keep <= n_keep;
        end
    end

    assign o_keep = r_keep;

endmodule

// ===== src/hcd_skid.sv =====
// Output register with a skid stage between the pipeline and the result channel.
module hcd_skid (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  hcd_pkg::t_out_item i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output hcd_pkg::t_out_item o_item
);
    import hcd_pkg::*;

    logic      r_out_vld;
    logic      r_skid_vld;
    logic      n_out_vld;
    logic      n_skid_vld;
    logic      load_in;
    logic      load_skid;
    logic      drain_skid;
    t_out_item r_out;
    t_out_item r_skid;

    always_comb begin
        load_in    = 1'b0;
        load_skid  = 1'b0;
        drain_skid = 1'b0;
        n_out_vld  = r_out_vld;
        n_skid_vld = r_skid_vld;
        if (r_skid_vld) begin
            if (i_ready) begin
                drain_skid = 1'b1;
                n_skid_vld = 1'b0;
            end
        end else if (i_valid) begin
            // A new request lands in the skid stage only while the output stalls.
            if (!r_out_vld || i_ready) begin
                load_in   = 1'b1;
                n_out_vld = 1'b1;
            end else begin
                load_skid  = 1'b1;
                n_skid_vld = 1'b1;
            end
        end else if (i_ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_out_vld  <= n_out_vld;
            r_skid_vld <= n_skid_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (drain_skid) begin
            r_out <= r_skid;
        end else if (load_in) begin
            r_out <= i_item;
        end
        if (load_skid) begin
            r_skid <= i_item;
        end
    end

    assign o_ready = !r_skid_vld;
    assign o_valid = r_out_vld;
    assign o_item  = r_out;

endmodule

// ===== src/hsv_color_depth_point_filter_unit.sv =====
// Top level of the HSV color and depth point filter.
//
//  channel   direction  handshake                   payload
//  in        request    i_in_valid / o_in_ready     i_in_item  (t_in_item)
//  out       result     o_out_valid / i_out_ready   o_out_item (t_out_item)
//  config    write      i_cfg_we                    i_cfg_idx, i_cfg_data
//
// One point is accepted per cycle while the skid stage is free; its result passes through two
// front stages (the first loads on the accepting edge), the 15-stage divider, two back stages
// and the output register.
// Reset clears the pipeline and output valid bits and sets the thresholds to their defaults.
// When the result channel stalls, the skid stage catches one point and then the whole
// pipeline holds, so no point is dropped or repeated.
module hsv_color_depth_point_filter_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  hcd_pkg::t_in_item              i_in_item,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output hcd_pkg::t_out_item             o_out_item,
    input  logic                           i_cfg_we,
    input  logic [hcd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [hcd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import hcd_pkg::*;

    t_cfg                 r_cfg;
    logic                 en;
    logic                 r_vld [PIPE_DEPTH];
    t_in_item             r_pay [PIPE_DEPTH];
    t_div_ops             ops;
    logic [DIV_QUO_W-1:0] sat_quo;
    logic [DIV_QUO_W-1:0] hue_quo;
    logic [Q12_W-1:0]     r_val_pipe [DIV_QUO_W];
    logic                 keep;
    t_in_item             last_pay;
    t_out_item            pipe_out;
    logic                 skid_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_DEPTH_LIMIT: r_cfg.depth_limit   <= i_cfg_data;
                CFG_TARGET_HUE:  r_cfg.target_hue    <= i_cfg_data[HUE_W-1:0];
                CFG_HUE_TOL:     r_cfg.hue_tolerance <= i_cfg_data[HUE_W-1:0];
                CFG_SAT_LOW:     r_cfg.sat_low       <= i_cfg_data[Q12_W-1:0];
                CFG_SAT_HIGH:    r_cfg.sat_high      <= i_cfg_data[Q12_W-1:0];
                CFG_VAL_LOW:     r_cfg.val_low       <= i_cfg_data[Q12_W-1:0];
                CFG_VAL_HIGH:    r_cfg.val_high      <= i_cfg_data[Q12_W-1:0];
                default: ;
            endcase
        end
    end

    // All stages move together whenever the skid stage is free.
    assign en         = skid_ready;
    assign o_in_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < PIPE_DEPTH; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_in_valid;
            for (int k = 1; k < PIPE_DEPTH; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pay[0] <= i_in_item;
            for (int k = 1; k < PIPE_DEPTH; k++) begin
                r_pay[k] <= r_pay[k-1];
            end
        end
    end

    hcd_front u_front (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_item (i_in_item),
        .o_ops  (ops)
    );

    hcd_div u_div_sat (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (ops.sat_num),
        .i_den (ops.sat_den),
        .o_quo (sat_quo)
    );

    hcd_div u_div_hue (
        .i_clk (i_clk),
        .i_en  (en),
        .i_num (ops.hue_num),
        .i_den (ops.hue_den),
        .o_quo (hue_quo)
    );

    // The value is ready early and waits beside the divider stages.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_val_pipe[0] <= ops.val;
            for (int k = 1; k < DIV_QUO_W; k++) begin
                r_val_pipe[k] <= r_val_pipe[k-1];
            end
        end
    end

    hcd_back u_back (
        .i_clk      (i_clk),
        .i_en       (en),
        .i_cfg      (r_cfg),
        .i_sat_quo  (sat_quo),
        .i_hue_quo  (hue_quo),
        .i_val      (r_val_pipe[DIV_QUO_W-1]),
        .i_item_div (r_pay[DIV_OUT_TAP]),
        .i_item_p1  (r_pay[BACK_P1_TAP]),
        .o_keep     (keep)
    );

    always_comb begin
        last_pay           = r_pay[PIPE_DEPTH-1];
        pipe_out.keep      = keep;
        pipe_out.out_x     = last_pay.x_coord;
        pipe_out.out_y     = last_pay.y_coord;
        pipe_out.out_z     = last_pay.z_coord;
        pipe_out.out_red   = last_pay.red;
        pipe_out.out_green = last_pay.green;
        pipe_out.out_blue  = last_pay.blue;
        pipe_out.out_last  = last_pay.last_in_cloud;
    end

    hcd_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vld[PIPE_DEPTH-1]),
        .o_ready (skid_ready),
        .i_item  (pipe_out),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_item)
    );

endmodule

// ===== verif/hcd_filter_checker.sv =====
// Checker for the HSV color and depth point filter: predicts each keep flag and compares results.
`timescale 1ns / 100ps

module hcd_filter_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_ready,
    input  hcd_pkg::t_in_item              i_in_item,
    input  logic                           i_out_valid,
    input  logic                           i_out_ready,
    input  hcd_pkg::t_out_item             i_out_item,
    input  logic                           i_cfg_we,
    input  logic [hcd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [hcd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                             o_fail_count,
    output int                             o_pending
);
    import hcd_pkg::*;

    localparam int HUE_TURN    = 23040;
    localparam int HUE_STEP    = 3840;
    localparam int Q12_ONE     = 4096;
    localparam int COLOR_MAX   = 255;
    localparam int REPORT_MAX  = 10;

    t_cfg      thresholds;
    t_out_item expected_points[$];
    int        mismatch_count;
    int        results_seen;

    // Round half up of num / den with den > 0.
    function automatic int round_div(int num, int den);
        return (2 * num + den) / (2 * den);
    endfunction

    function automatic t_out_item filter_point(t_in_item p, t_cfg c);
        int r, g, b, mx, mn, diff, raw, hue, sat, val, target, d1, d2, hue_gap;
        t_out_item o;
        r   = int'(p.red);
        g   = int'(p.green);
        b   = int'(p.blue);
        mx  = (r > g) ? r : g;
        mx  = (b > mx) ? b : mx;
        mn  = (r < g) ? r : g;
        mn  = (b < mn) ? b : mn;
        val = round_div(mx * Q12_ONE, COLOR_MAX);
        hue = 0;
        sat = 0;
        if (mx != 0) begin
            diff = mx - mn;
            sat  = round_div(diff * Q12_ONE, mx);
            if (diff != 0) begin
                // Red is tested first, then green, so ties go to the earlier sector.
                if (mx == r) begin
                    raw = (g >= b) ? HUE_STEP * (g - b) : HUE_TURN * diff - HUE_STEP * (b - g);
                end else if (mx == g) begin
                    raw = 2 * HUE_STEP * diff + HUE_STEP * (b - r);
                end else begin
                    raw = 4 * HUE_STEP * diff + HUE_STEP * (r - g);
                end
                hue = round_div(raw, diff);
                if (hue >= HUE_TURN) begin
                    hue = hue - HUE_TURN;
                end
            end
        end
        target  = int'(c.target_hue);
        d1      = (hue >= target) ? hue - target : target - hue;
        d2      = (d1 <= HUE_TURN) ? HUE_TURN - d1 : d1 - HUE_TURN;
        hue_gap = (d1 < d2) ? d1 : d2;

        o.keep      = ($signed(p.z_coord) < $signed(c.depth_limit)) &&
                      (hue_gap < int'(c.hue_tolerance)) &&
                      (sat > int'(c.sat_low)) && (sat < int'(c.sat_high)) &&
                      (val > int'(c.val_low)) && (val < int'(c.val_high));
        o.out_x     = p.x_coord;
        o.out_y     = p.y_coord;
        o.out_z     = p.z_coord;
        o.out_red   = p.red;
        o.out_green = p.green;
        o.out_blue  = p.blue;
        o.out_last  = p.last_in_cloud;
        return o;
    endfunction

    task automatic note_mismatch(string field, logic [31:0] want, logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX) begin
            $display("[%0t] point %0d, field %s: expected %0h, got %0h",
                     $realtime, results_seen, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            thresholds = CFG_RESET;
            expected_points.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_points.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX) begin
                        $display("[%0t] result with no point outstanding: %0h",
                                 $realtime, i_out_item);
                    end
                end else begin
                    want = expected_points.pop_front();
                    if (i_out_item.keep !== want.keep)
                        note_mismatch("keep", 32'(want.keep), 32'(i_out_item.keep));
                    if (i_out_item.out_x !== want.out_x)
                        note_mismatch("out_x", want.out_x, i_out_item.out_x);
                    if (i_out_item.out_y !== want.out_y)
                        note_mismatch("out_y", want.out_y, i_out_item.out_y);
                    if (i_out_item.out_z !== want.out_z)
                        note_mismatch("out_z", want.out_z, i_out_item.out_z);
                    if (i_out_item.out_red !== want.out_red)
                        note_mismatch("out_red", 32'(want.out_red), 32'(i_out_item.out_red));
                    if (i_out_item.out_green !== want.out_green)
                        note_mismatch("out_green", 32'(want.out_green),
                                      32'(i_out_item.out_green));
                    if (i_out_item.out_blue !== want.out_blue)
                        note_mismatch("out_blue", 32'(want.out_blue),
                                      32'(i_out_item.out_blue));
                    if (i_out_item.out_last !== want.out_last)
                        note_mismatch("out_last", 32'(want.out_last),
                                      32'(i_out_item.out_last));
                end
                results_seen++;
            end
            if (i_in_valid && i_in_ready) begin
                expected_points = {expected_points, filter_point(i_in_item, thresholds)};
            end
            // Writes only land while the pipeline is empty, so their order here is free.
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_DEPTH_LIMIT: thresholds.depth_limit   = i_cfg_data;
                    CFG_TARGET_HUE:  thresholds.target_hue    = i_cfg_data[HUE_W-1:0];
                    CFG_HUE_TOL:     thresholds.hue_tolerance = i_cfg_data[HUE_W-1:0];
                    CFG_SAT_LOW:     thresholds.sat_low       = i_cfg_data[Q12_W-1:0];
                    CFG_SAT_HIGH:    thresholds.sat_high      = i_cfg_data[Q12_W-1:0];
                    CFG_VAL_LOW:     thresholds.val_low       = i_cfg_data[Q12_W-1:0];
                    CFG_VAL_HIGH:    thresholds.val_high      = i_cfg_data[Q12_W-1:0];
                    default: ;
                endcase
            end
        end
        o_fail_count <= mismatch_count;
        o_pending    <= expected_points.size();
    end

endmodule

// ===== verif/hsv_color_depth_point_filter_unit_tb.sv =====
// Testbench top for the HSV color and depth point filter: stimulus, threshold phases and verdict.
`timescale 1ns / 100ps

module hsv_color_depth_point_filter_unit_tb;
    import hcd_pkg::*;

    localparam int RESET_CYCLES    = 9;
    localparam int DRAIN_CYCLES    = 30;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 3'd7;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    t_in_item              in_item   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b1;
    t_out_item             out_item;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    int                    fail_count;
    int                    pending;
    int                    idle_cycles = 0;
    int                    gapless_left = 0;
    logic signed [31:0]    cur_depth = CFG_RESET.depth_limit;

    hsv_color_depth_point_filter_unit i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    hcd_filter_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_item    (in_item),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_item   (out_item),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    // Result side stalls: mostly short bursts, a few long stalls and long open stretches.
    initial begin
        int pick;
        int hold;
        forever begin
            pick = $urandom_range(0, 99);
            if (pick < 50) begin
                out_ready <= 1'b1;
                hold = $urandom_range(1, 8);
            end else if (pick < 65) begin
                out_ready <= 1'b1;
                hold = $urandom_range(40, 120);
            end else if (pick < 92) begin
                out_ready <= 1'b0;
                hold = $urandom_range(1, 3);
            end else begin
                out_ready <= 1'b0;
                hold = $urandom_range(15, 60);
            end
            repeat (hold) @(posedge clk);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || cfg_we || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("Test completed with failures");
        $finish;
    end

    function automatic int pick_gap();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45) return 0;
        if (pick < 85) return $urandom_range(1, 3);
        if (pick < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_in_item mk_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                          int r, int g, int b, bit last);
        t_in_item p;
        p.x_coord       = x;
        p.y_coord       = y;
        p.z_coord       = z;
        p.red           = 8'(r);
        p.green         = 8'(g);
        p.blue          = 8'(b);
        p.last_in_cloud = last;
        return p;
    endfunction

    function automatic t_in_item random_point();
        t_in_item p;
        int zmode;
        int cmode;
        int hi;
        int lo;
        int mid;
        p.x_coord = $urandom;
        p.y_coord = $urandom;
        zmode = $urandom_range(0, 9);
        if (zmode < 3) begin
            p.z_coord = $urandom;
        end else if (zmode < 6) begin
            p.z_coord = cur_depth + (int'($urandom_range(0, 4000)) - 2000);
        end else begin
            p.z_coord = $urandom_range(0, 120) << 16;
        end
        cmode = $urandom_range(0, 9);
        if (cmode < 4) begin
            p.red   = 8'($urandom_range(0, 255));
            p.green = 8'($urandom_range(0, 255));
            p.blue  = 8'($urandom_range(0, 255));
        end else if (cmode < 8) begin
            // Strongly saturated colors, one channel high and one low, in any order.
            hi  = $urandom_range(150, 255);
            lo  = $urandom_range(0, 60);
            mid = $urandom_range(lo, hi);
            case ($urandom_range(0, 5))
                0: {p.red, p.green, p.blue} = {8'(hi), 8'(mid), 8'(lo)};
                1: {p.red, p.green, p.blue} = {8'(hi), 8'(lo), 8'(mid)};
                2: {p.red, p.green, p.blue} = {8'(mid), 8'(hi), 8'(lo)};
                3: {p.red, p.green, p.blue} = {8'(lo), 8'(hi), 8'(mid)};
                4: {p.red, p.green, p.blue} = {8'(mid), 8'(lo), 8'(hi)};
                default: {p.red, p.green, p.blue} = {8'(lo), 8'(mid), 8'(hi)};
            endcase
        end else if (cmode == 8) begin
            p.red   = 8'($urandom_range(0, 255));
            p.green = p.red;
            p.blue  = p.red;
        end else begin
            p.red   = 8'($urandom_range(0, 6));
            p.green = 8'($urandom_range(0, 6));
            p.blue  = 8'($urandom_range(0, 6));
        end
        p.last_in_cloud = ($urandom_range(0, 15) == 0);
        return p;
    endfunction

    // Holds the request until it is taken; the next call keeps valid high when there is no gap.
    task automatic send_point(input t_in_item p);
        int gap;
        if (gapless_left > 0) begin
            gap = 0;
            gapless_left--;
        end else begin
            gap = pick_gap();
            if ($urandom_range(0, 39) == 0) gapless_left = $urandom_range(20, 50);
        end
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= p;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic send_random(input int count);
        repeat (count) send_point(random_point());
    endtask

    // The extra edge lets the outstanding count take in the last accepted request.
    task automatic finish_phase();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    // Optionally fills the bits above a register's width, which the block must drop.
    function automatic logic [31:0] with_junk(logic [31:0] v, int w, bit junk);
        logic [31:0] upper;
        upper = $urandom;
        return junk ? (v | (upper << w)) : v;
    endfunction

    task automatic apply_settings(input t_cfg c, input bit junk);
        write_reg(CFG_DEPTH_LIMIT, c.depth_limit);
        write_reg(CFG_TARGET_HUE, with_junk(32'(c.target_hue), HUE_W, junk));
        write_reg(CFG_HUE_TOL, with_junk(32'(c.hue_tolerance), HUE_W, junk));
        write_reg(CFG_SAT_LOW, with_junk(32'(c.sat_low), Q12_W, junk));
        write_reg(CFG_SAT_HIGH, with_junk(32'(c.sat_high), Q12_W, junk));
        write_reg(CFG_VAL_LOW, with_junk(32'(c.val_low), Q12_W, junk));
        write_reg(CFG_VAL_HIGH, with_junk(32'(c.val_high), Q12_W, junk));
        // A write past the register list must leave every threshold alone.
        write_reg(CFG_UNUSED_IDX, $urandom);
        cfg_we    <= 1'b0;
        cur_depth  = c.depth_limit;
    endtask

    task automatic send_directed();
        send_point(mk_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 255, 0, 0, 1'b0));
        send_point(mk_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 200, 30, 30, 1'b0));
        send_point(mk_point(32'h0, 32'hFFFF_FFFF, cur_depth, 200, 30, 30, 1'b0));
        send_point(mk_point(32'hFFFF_FFFF, 32'h0, cur_depth - 1, 200, 30, 30, 1'b1));
        send_point(mk_point(32'h5555_5555, 32'hAAAA_AAAA, 32'h7FFF_FFFF, 200, 30, 30, 1'b0));
        send_point(mk_point(32'hAAAA_AAAA, 32'h5555_5555, 32'h0001_0000, 0, 0, 0, 1'b0));
        send_point(mk_point(32'h1, 32'h2, 32'h0001_0000, 255, 255, 255, 1'b0));
        send_point(mk_point(32'h3, 32'h4, 32'h0001_0000, 128, 128, 128, 1'b0));
        send_point(mk_point(32'h5, 32'h6, 32'h0002_0000, 0, 255, 0, 1'b0));
        send_point(mk_point(32'h7, 32'h8, 32'h0002_0000, 0, 0, 255, 1'b0));
        send_point(mk_point(32'h9, 32'hA, 32'h0002_0000, 255, 255, 0, 1'b0));
        send_point(mk_point(32'hB, 32'hC, 32'h0002_0000, 0, 255, 255, 1'b0));
        send_point(mk_point(32'hD, 32'hE, 32'h0002_0000, 255, 0, 255, 1'b1));
        // Red sector with blue above green wraps the hue to just below a full turn.
        send_point(mk_point(32'h10, 32'h11, 32'h0003_0000, 200, 20, 30, 1'b0));
        send_point(mk_point(32'h12, 32'h13, 32'h0003_0000, 255, 0, 1, 1'b0));
        send_point(mk_point(32'h14, 32'h15, 32'h0003_0000, 200, 30, 20, 1'b0));
        send_point(mk_point(32'h16, 32'h17, 32'h0003_0000, 1, 0, 0, 1'b0));
        send_point(mk_point(32'h18, 32'h19, 32'h0003_0000, 0, 0, 1, 1'b0));
        send_point(mk_point(32'h1A, 32'h1B, 32'h0003_0000, 255, 254, 254, 1'b0));
        send_point(mk_point(32'h1C, 32'h1D, 32'h0003_0000, 1, 1, 0, 1'b0));
        send_point(mk_point(32'h1E, 32'h1F, 32'hFFFF_0000, 230, 60, 50, 1'b1));
    endtask

    function automatic t_cfg random_settings();
        t_cfg c;
        c.depth_limit   = ($urandom_range(0, 3) == 0) ? $urandom : ($urandom_range(0, 200) << 16);
        c.target_hue    = 15'($urandom_range(0, 23039));
        c.hue_tolerance = 15'($urandom_range(0, 23040));
        c.sat_low       = 13'($urandom_range(0, 2500));
        c.sat_high      = 13'($urandom_range(1500, 4096));
        c.val_low       = 13'($urandom_range(0, 2500));
        c.val_high      = 13'($urandom_range(1500, 4096));
        return c;
    endfunction

    initial begin
        t_cfg c;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Thresholds straight from reset.
        send_directed();
        send_random(100);
        finish_phase();

        // Wide open: nearly everything with some color passes.
        c = '{depth_limit: 32'sh7FFF_FFFF, target_hue: 15'd15360, hue_tolerance: 15'd23040,
              sat_low: 13'd0, sat_high: 13'd4096, val_low: 13'd0, val_high: 13'd4096};
        apply_settings(c, 1'b0);
        send_directed();
        send_random(100);
        finish_phase();

        // Register extremes: target beyond a full turn, bounds crossed, nothing kept.
        c = '{depth_limit: 32'sh8000_0000, target_hue: 15'd32767, hue_tolerance: 15'd32767,
              sat_low: 13'd8191, sat_high: 13'd0, val_low: 13'd8191, val_high: 13'd0};
        apply_settings(c, 1'b0);
        send_random(50);
        finish_phase();

        c = '{depth_limit: 32'sh7FFF_FFFF, target_hue: 15'd23039, hue_tolerance: 15'd2000,
              sat_low: 13'd0, sat_high: 13'd8191, val_low: 13'd0, val_high: 13'd8191};
        apply_settings(c, 1'b0);
        send_random(50);
        finish_phase();

        for (int phase = 0; phase < 3; phase++) begin
            c = random_settings();
            if (phase == 0) c.hue_tolerance = 15'd0;
            apply_settings(c, 1'b1);
            send_random(100);
            finish_phase();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/hcd_pkg.sv
src/hcd_front.sv
src/hcd_div.sv
src/hcd_back.sv
src/hcd_skid.sv
src/hsv_color_depth_point_filter_unit.sv
verif/hcd_filter_checker.sv
verif/hsv_color_depth_point_filter_unit_tb.sv
